// ----- hw/rtl/psrl_pkg.sv -----
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types, constants and hash function of the per-source rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int unsigned TableEntries = 8192;
  localparam int unsigned TableWays    = 4;
  localparam int unsigned SetCount     = TableEntries / TableWays;
  localparam int unsigned SetBits      = $clog2(SetCount);
  localparam int unsigned WayBits      = (TableWays > 1) ? $clog2(TableWays) : 1;
  localparam int unsigned TreeLevels   = (TableWays > 1) ? $clog2(TableWays) : 0;
  localparam int unsigned PlruBits     = 7;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrBits  = $clog2(FifoDepth);

  localparam logic [15:0] EthHdrBytes   = 16'd14;
  localparam logic [15:0] Ipv4MinBytes  = 16'd34;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [31:0] HashMul       = 32'h9E37_79B1;
  localparam logic [31:0] MaxPktReset   = 32'd100;
  localparam logic [47:0] WinLenReset   = 48'd1000000000;

  localparam logic [0:0] CfgMaxPkt = 1'b0;
  localparam logic [0:0] CfgWinLen = 1'b1;

  localparam logic [2:0] OutPass    = 3'd0;
  localparam logic [2:0] OutNew     = 3'd1;
  localparam logic [2:0] OutRestart = 3'd2;
  localparam logic [2:0] OutWithin  = 3'd3;
  localparam logic [2:0] OutOver    = 3'd4;

  // classified item handed from front to back
  typedef struct packed {
    logic        bypass;
    logic [SetBits-1:0] set;
    logic [31:0] src;
    logic [63:0] now;
  } item_t;

  function automatic logic [SetBits-1:0] set_hash(input logic [31:0] prod);
    logic [31:0] h;
    h = prod ^ (prod >> 16);
    return h[SetBits-1:0];
  endfunction

endpackage

// ----- hw/rtl/per_source_rate_limiter_top.sv -----
// ----------------------------------------------------------------------------
// per_source_rate_limiter_top
// Fixed-window per-source rate limiter with a 4-way set-associative table.
// ----------------------------------------------------------------------------
// A front queue of four entries takes a frame whenever start_i is high and
// busy_o low. Non-IPv4 or short frames are reported straight from idle by the
// back sequencer; table frames go through read, compare, update and report
// over the single table memory port. Results appear for one cycle on done_o
// and cannot be held off. After reset a clearing pass sweeps all 2048 sets
// of the table, one set per cycle, during which busy_o is high; configuration is taken anytime.
module per_source_rate_limiter_top import psrl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [31:0] source_address_i,
  input  logic [63:0] time_ns_i,
  output logic        done_o,
  output logic        drop_o,
  output logic [2:0]  outcome_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [31:0] max_pkt_q;
  logic [47:0] win_len_q;
  logic        pop, empty, clearing, fbusy;
  item_t       item;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = fbusy || clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q <= MaxPktReset;
      win_len_q <= WinLenReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMaxPkt: max_pkt_q <= cfg_data_i[31:0];
        CfgWinLen: win_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psrl_front u_front (
    .clk_i, .rst_ni,
    .start_i(start_i && !clearing),
    .busy_o(fbusy),
    .frame_length_i, .ether_type_i, .source_address_i, .time_ns_i,
    .pop_i(pop), .empty_o(empty), .item_o(item)
  );

  psrl_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .item_i(item), .pop_o(pop),
    .max_pkt_i(max_pkt_q), .win_len_i(win_len_q),
    .clearing_o(clearing),
    .done_o, .drop_o, .outcome_o
  );

endmodule

// ----- hw/rtl/psrl_front.sv -----
// ----------------------------------------------------------------------------
// psrl_front
// Accepts frame summaries, classifies them and pushes them into a small queue.
// ----------------------------------------------------------------------------
module psrl_front import psrl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [31:0] source_address_i,
  input  logic [63:0] time_ns_i,
  input  logic        pop_i,
  output logic        empty_o,
  output item_t       item_o
);

  item_t                mem_q [FifoDepth];
  logic [FifoPtrBits:0] wr_q, rd_q;
  logic                 push;
  item_t                it;
  logic [31:0]          prod;

  assign busy_o  = (wr_q - rd_q) == (FifoPtrBits+1)'(FifoDepth);
  assign empty_o = wr_q == rd_q;
  assign push    = start_i && !busy_o;
  assign item_o  = mem_q[rd_q[FifoPtrBits-1:0]];
  assign prod    = source_address_i * HashMul;

  always_comb begin
    it.bypass = (frame_length_i < EthHdrBytes) || (ether_type_i != EtherTypeIpv4) ||
                (frame_length_i < Ipv4MinBytes);
    it.set    = set_hash(prod);
    it.src    = source_address_i;
    it.now    = time_ns_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q[FifoPtrBits-1:0]] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
    end
  end

endmodule

// ----- hw/rtl/psrl_back.sv -----
// ----------------------------------------------------------------------------
// psrl_back
// Table lookup and update sequencer: read set, compare ways, write back; also clears the table after reset.
// ----------------------------------------------------------------------------
module psrl_back import psrl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  item_t       item_i,
  output logic        pop_o,
  input  logic [31:0] max_pkt_i,
  input  logic [47:0] win_len_i,
  output logic        clearing_o,
  output logic        done_o,
  output logic        drop_o,
  output logic [2:0]  outcome_o
);

  typedef enum logic [2:0] {StClear, StIdle, StRead, StCmp, StCalc} state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] src;
    logic [63:0] start;
    logic [31:0] cnt;
  } slot_t;

  slot_t                 ram_q [TableWays][SetCount];
  logic [PlruBits-1:0]   plru_q [SetCount];
  slot_t                 rd_q [TableWays];
  logic [PlruBits-1:0]   prd_q;

  state_e              st_q;
  logic [SetBits:0]    clr_q;
  item_t               it_q;
  logic                hit_q;
  logic [WayBits-1:0]  way_q;
  logic                wr_en;
  logic [WayBits-1:0]  wr_way;
  slot_t               wr_slot;
  logic [SetBits-1:0]  wr_set;
  logic [PlruBits-1:0] wr_plru;
  logic                hit;
  logic                has_empty;
  logic [WayBits-1:0]  hit_way, empty_way, victim;
  logic [PlruBits-1:0] touched;
  logic [63:0]         elapsed;
  logic [31:0]         new_cnt;
  logic [2:0]          oc;
  logic                expired;

  // way compare and pseudo-LRU walk
  always_comb begin
    logic [2:0] node;
    logic       dir;
    logic [WayBits-1:0] v;
    hit = 1'b0; has_empty = 1'b0; hit_way = '0; empty_way = '0;
    for (int w = TableWays - 1; w >= 0; w--) begin
      if (rd_q[w].valid) begin
        if (rd_q[w].src == it_q.src) begin
          hit = 1'b1; hit_way = WayBits'(w);
        end
      end else begin
        has_empty = 1'b1; empty_way = WayBits'(w);
      end
    end
    node = 3'd1; v = '0;
    for (int i = 0; i < TreeLevels; i++) begin
      dir  = prd_q[node - 3'd1];
      v    = WayBits'({v, dir});
      node = {node[1:0], dir};
    end
    victim = ({1'b0, v} >= (WayBits+1)'(TableWays)) ? WayBits'(v - WayBits'(TableWays)) : v;
  end

  always_comb begin
    logic [2:0] node;
    logic       dir;
    touched = prd_q;
    node = 3'd1;
    for (int i = 0; i < TreeLevels; i++) begin
      dir = way_q[TreeLevels - 1 - i];
      touched[node - 3'd1] = !dir;
      node = {node[1:0], dir};
    end
  end

  assign elapsed = it_q.now - rd_q[way_q].start;
  assign expired = elapsed > {16'd0, win_len_i};

  always_comb begin
    wr_slot.valid = 1'b1;
    wr_slot.src   = it_q.src;
    if (!hit_q || expired) begin
      wr_slot.start = it_q.now;
      new_cnt = 32'd1;
    end else begin
      wr_slot.start = rd_q[way_q].start;
      new_cnt = (rd_q[way_q].cnt == '1) ? rd_q[way_q].cnt : rd_q[way_q].cnt + 32'd1;
    end
    wr_slot.cnt = new_cnt;
    if (!hit_q) oc = OutNew;
    else if (new_cnt > max_pkt_i) oc = OutOver;
    else if (expired) oc = OutRestart;
    else oc = OutWithin;
  end

  assign clearing_o = st_q == StClear;
  assign pop_o      = st_q == StIdle && !empty_i;
  assign wr_en      = st_q == StCalc || st_q == StClear;
  assign wr_way     = way_q;
  assign wr_set     = (st_q == StClear) ? clr_q[SetBits-1:0] : it_q.set;
  assign wr_plru    = (st_q == StClear) ? '0 : touched;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int w = 0; w < TableWays; w++) begin
        if (st_q == StClear) ram_q[w][wr_set] <= '0;
        else if (WayBits'(w) == wr_way) ram_q[w][wr_set] <= wr_slot;
      end
      plru_q[wr_set] <= wr_plru;
    end
    if (st_q == StRead) begin
      for (int w = 0; w < TableWays; w++) rd_q[w] <= ram_q[w][it_q.set];
      prd_q <= plru_q[it_q.set];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (st_q == StCmp) begin
      hit_q <= hit;
      way_q <= hit ? hit_way : (has_empty ? empty_way : victim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StClear;
      clr_q     <= '0;
      done_o    <= 1'b0;
      drop_o    <= 1'b0;
      outcome_o <= OutPass;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (SetBits+1)'(SetCount - 1)) st_q <= StIdle;
        end
        StIdle: if (pop_o) begin
          if (item_i.bypass) begin
            done_o <= 1'b1; drop_o <= 1'b0; outcome_o <= OutPass;
          end else begin
            st_q <= StRead;
          end
        end
        StRead: st_q <= StCmp;
        StCmp:  st_q <= StCalc;
        StCalc: begin
          done_o    <= 1'b1;
          drop_o    <= oc == OutOver;
          outcome_o <= oc;
          st_q      <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule
